// ===== hw/rtl/sensor_frame_aggregator_assert.svh =====
// Assertion macros shared by the checker of the sensor frame aggregator.
// Self-contained: no other file is needed.
`ifndef SENSOR_FRAME_AGGREGATOR_ASSERT_SVH
`define SENSOR_FRAME_AGGREGATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sfa_pkg.sv =====
// Shared constants, types and command format of the sensor frame aggregator.
// Used by every module of the block but sfa_ram; depends on nothing.
`default_nettype none

package sfa_pkg;

  localparam int SLOTS       = 4;
  localparam int DATA_BYTES  = 34;
  localparam int FRAME_BYTES = DATA_BYTES + 2;
  localparam int TIME_POS    = SLOTS * FRAME_BYTES;
  localparam int STORE_BYTES = TIME_POS + 4;
  localparam int LANES       = 4;
  localparam int LANE_W      = 2;
  localparam int WORDS       = (STORE_BYTES + LANES - 1) / LANES;
  localparam int POS_W       = $clog2(STORE_BYTES);
  localparam int ADDR_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WCNT_W      = $clog2(WORDS + 1);
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DIDX_W      = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam int IN_W    = 40;
  localparam int OUT_W   = 32;
  localparam int PADDR_W = 3;

  localparam logic [7:0] LEFT_BASE  = 8'd1;
  localparam logic [7:0] RIGHT_BASE = 8'd9;

  // Register index of right_foot (byte address 4 * index).
  localparam logic [PADDR_W-3:0] REG_RIGHT_FOOT = '0;

  typedef enum logic {
    CMD_HEADER,
    CMD_DATA
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [POS_W-1:0]  pos;
    logic [7:0]        hdr0;
    logic [7:0]        data;
    logic [31:0]       elapsed;
    logic              emit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used as one byte lane of the frame store.
`default_nettype none

module sfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sfa_cmd_queue.sv =====
// Two-entry command queue between the parser front and the store back end.
// Depends on sfa_pkg for the command type and depth.
`default_nettype none

module sfa_cmd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  sfa_pkg::cmd_t      cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output sfa_pkg::cmd_t      cmd_o,
  output logic               empty_o
);

  sfa_pkg::cmd_t                 entry_q [sfa_pkg::QDEPTH];
  logic [sfa_pkg::QPTR_W-1:0]    wr_ptr_q;
  logic [sfa_pkg::QPTR_W-1:0]    rd_ptr_q;
  logic [sfa_pkg::QCNT_W-1:0]    cnt_q;

  assign full_o  = (cnt_q == sfa_pkg::QCNT_W'(sfa_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sfa_front.sv =====
// Link parser: matches header pairs, tracks slot, data index and frame count,
// and turns each byte that changes the store into a command. Uses sfa_pkg.
`default_nettype none

module sfa_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    link_byte_i,
  input  wire logic [31:0]   elapsed_us_i,
  input  wire logic          right_foot_i,
  output logic               push_o,
  output sfa_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    PH_HDR0 = 2'd0,
    PH_HDR1 = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  phase_e                       phase_q;
  logic [7:0]                   first_q;
  logic [sfa_pkg::SLOT_W-1:0]   slot_q;
  logic [sfa_pkg::DIDX_W-1:0]   didx_q;
  logic [sfa_pkg::SLOT_W-1:0]   fcnt_q;

  logic [7:0]                   base;
  logic [7:0]                   off;
  logic                         match;
  logic [sfa_pkg::SLOT_W-1:0]   slot_new;
  logic                         data_last;
  logic                         frame_last;

  // A pair (a, a+1) names slot (a - base) / 2 when that is below SLOTS.
  always_comb begin
    base     = right_foot_i ? sfa_pkg::RIGHT_BASE : sfa_pkg::LEFT_BASE;
    off      = first_q - base;
    match    = (first_q >= base) && !off[0] && ((off >> 1) < 8'(sfa_pkg::SLOTS)) &&
               ({1'b0, link_byte_i} == ({1'b0, first_q} + 9'd1));
    slot_new = sfa_pkg::SLOT_W'(off >> 1);
  end

  assign data_last  = (didx_q == sfa_pkg::DIDX_W'(sfa_pkg::DATA_BYTES - 1));
  assign frame_last = (fcnt_q == sfa_pkg::SLOT_W'(sfa_pkg::SLOTS - 1));

  always_comb begin
    push_o        = 1'b0;
    cmd_o.kind    = sfa_pkg::CMD_DATA;
    cmd_o.pos     = sfa_pkg::POS_W'(slot_q * sfa_pkg::FRAME_BYTES + 2 + didx_q);
    cmd_o.hdr0    = first_q;
    cmd_o.data    = link_byte_i;
    cmd_o.elapsed = elapsed_us_i;
    cmd_o.emit    = data_last && frame_last;
    case (phase_q)
      PH_HDR1: begin
        push_o     = accept_i && match;
        cmd_o.kind = sfa_pkg::CMD_HEADER;
        cmd_o.pos  = sfa_pkg::POS_W'(slot_new * sfa_pkg::FRAME_BYTES);
        cmd_o.emit = 1'b0;
      end
      PH_DATA: begin
        push_o = accept_i;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      first_q <= '0;
      slot_q  <= '0;
      didx_q  <= '0;
      fcnt_q  <= '0;
    end else if (accept_i) begin
      case (phase_q)
        PH_HDR1: begin
          if (match) begin
            slot_q  <= slot_new;
            didx_q  <= '0;
            phase_q <= PH_DATA;
          end else begin
            phase_q <= PH_HDR0;
          end
        end
        PH_DATA: begin
          if (data_last) begin
            didx_q  <= '0;
            phase_q <= PH_HDR0;
            fcnt_q  <= frame_last ? '0 : fcnt_q + 1'b1;
          end else begin
            didx_q <= didx_q + 1'b1;
          end
        end
        default: begin
          first_q <= link_byte_i;
          phase_q <= PH_HDR1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sfa_back.sv =====
// Store back end: writes header, time and data bytes into four byte-lane RAMs
// and streams the store out as words. Uses sfa_pkg and sfa_ram.
`default_nettype none

module sfa_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_empty_i,
  input  sfa_pkg::cmd_t                   q_cmd_i,
  output logic                            q_pop_o,
  output logic                            m_tvalid_o,
  input  wire logic                       m_tready_i,
  output logic [sfa_pkg::OUT_W-1:0]       m_tdata_o,
  output logic                            m_tlast_o
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_WRITE,
    B_EMIT
  } bstate_e;

  localparam logic [2:0] STEP_HDR_B  = 3'd1;
  localparam logic [2:0] STEP_TIME_0 = 3'd2;
  localparam logic [2:0] STEP_TIME_1 = 3'd3;
  localparam logic [2:0] STEP_TIME_2 = 3'd4;
  localparam logic [2:0] STEP_TIME_3 = 3'd5;

  bstate_e                                       state_q;
  sfa_pkg::cmd_t                                 cmd_q;
  logic [2:0]                                    step_q;
  logic [sfa_pkg::WCNT_W-1:0]                    rd_cnt_q;
  logic                                          out_valid_q;
  logic                                          last_q;
  logic [sfa_pkg::LANES-1:0]                     vmask_q;
  logic [sfa_pkg::LANES-1:0][sfa_pkg::WORDS-1:0] lane_valid_q;

  logic                         wr_en;
  logic                         wr_last;
  logic [sfa_pkg::POS_W-1:0]    wr_pos;
  logic [7:0]                   wr_byte;
  logic [sfa_pkg::LANE_W-1:0]   wr_lane;
  logic [sfa_pkg::ADDR_W-1:0]   wr_addr;
  logic                         rd_en;
  logic [sfa_pkg::ADDR_W-1:0]   rd_addr;
  logic [7:0]                   lane_rdata [sfa_pkg::LANES];

  // A header command writes six bytes: two header bytes, then the
  // elapsed time most significant byte first. A data command writes one.
  always_comb begin
    wr_pos  = cmd_q.pos;
    wr_byte = cmd_q.data;
    if (cmd_q.kind == sfa_pkg::CMD_HEADER) begin
      case (step_q)
        STEP_HDR_B: begin
          wr_pos = cmd_q.pos + 1'b1;
        end
        STEP_TIME_0: begin
          wr_pos  = sfa_pkg::POS_W'(sfa_pkg::TIME_POS);
          wr_byte = cmd_q.elapsed[31:24];
        end
        STEP_TIME_1: begin
          wr_pos  = sfa_pkg::POS_W'(sfa_pkg::TIME_POS + 1);
          wr_byte = cmd_q.elapsed[23:16];
        end
        STEP_TIME_2: begin
          wr_pos  = sfa_pkg::POS_W'(sfa_pkg::TIME_POS + 2);
          wr_byte = cmd_q.elapsed[15:8];
        end
        STEP_TIME_3: begin
          wr_pos  = sfa_pkg::POS_W'(sfa_pkg::TIME_POS + 3);
          wr_byte = cmd_q.elapsed[7:0];
        end
        default: begin
          wr_byte = cmd_q.hdr0;
        end
      endcase
    end
  end

  assign wr_en   = (state_q == B_WRITE);
  assign wr_last = (cmd_q.kind != sfa_pkg::CMD_HEADER) || (step_q == STEP_TIME_3);
  assign wr_lane = wr_pos[sfa_pkg::LANE_W-1:0];
  assign wr_addr = sfa_pkg::ADDR_W'(wr_pos >> sfa_pkg::LANE_W);

  assign q_pop_o = (state_q == B_IDLE) && !q_empty_i;

  assign rd_en   = (state_q == B_EMIT) && (rd_cnt_q < sfa_pkg::WCNT_W'(sfa_pkg::WORDS)) &&
                   (!out_valid_q || m_tready_i);
  assign rd_addr = rd_cnt_q[sfa_pkg::ADDR_W-1:0];

  for (genvar i = 0; i < sfa_pkg::LANES; i++) begin : g_lane
    sfa_ram #(
      .WIDTH(8),
      .DEPTH(sfa_pkg::WORDS)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en && (wr_lane == sfa_pkg::LANE_W'(i))),
      .waddr_i(wr_addr),
      .wdata_i(wr_byte),
      .re_i   (rd_en),
      .raddr_i(rd_addr),
      .rdata_o(lane_rdata[i])
    );
    // Lane 0 holds the first byte of a word, which goes to the top bits.
    // A byte never written since reset reads as zero.
    assign m_tdata_o[sfa_pkg::OUT_W-1-8*i -: 8] = vmask_q[i] ? lane_rdata[i] : 8'h00;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tlast_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= '0;
    end else if (wr_en) begin
      lane_valid_q[wr_lane][wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cmd_q       <= '0;
      step_q      <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      vmask_q     <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            cmd_q   <= q_cmd_i;
            step_q  <= '0;
            state_q <= B_WRITE;
          end
        end
        B_WRITE: begin
          if (wr_last) begin
            rd_cnt_q <= '0;
            state_q  <= cmd_q.emit ? B_EMIT : B_IDLE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        B_EMIT: begin
          if (rd_en) begin
            rd_cnt_q    <= rd_cnt_q + 1'b1;
            out_valid_q <= 1'b1;
            last_q      <= (rd_cnt_q == sfa_pkg::WCNT_W'(sfa_pkg::WORDS - 1));
            for (int i = 0; i < sfa_pkg::LANES; i++) begin
              vmask_q[i] <= lane_valid_q[i][rd_addr];
            end
          end else if (out_valid_q && m_tready_i) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              last_q  <= 1'b0;
              state_q <= B_IDLE;
            end
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sensor_frame_aggregator.sv =====
// Top level of the sensor frame aggregator: stream ports, APB register and
// the front, queue and back parts. Depends on sfa_pkg and all sfa_* modules.
`default_nettype none

// The block parses a byte stream from a sensor-patch link. Each frame is a
// two-byte header pair followed by 34 data bytes. With right_foot at 0 the
// pairs (1,2), (3,4), (5,6) and (7,8) name slots 0 to 3; with right_foot at 1
// the pairs (9,10) to (15,16) do. A pair that names no slot is dropped and
// the next byte is taken as a new first header byte; right_foot is sampled
// when the second header byte arrives. A matched header is stored at the
// start of its slot, and the elapsed_us of that request is stored big-endian
// in store bytes 144 to 147. After every fourth completed frame, repeated
// slots included, the whole 148-byte store goes out as 37 big-endian words,
// tlast marking the 37th. The store is zero after reset (per-byte valid bits,
// so there is no clearing pass) and keeps old bytes between emissions.
// Timing: the parser takes one request per cycle while its two-entry command
// queue has room. The back end does one byte write per cycle into four
// byte-lane RAMs: a matched header costs a queue pop plus two header and four
// time writes, a data byte a queue pop and one write, a first header byte or a
// dropped pair nothing. An emission reads the RAMs through their registered
// read ports, then gives one word per cycle while the output is not stalled.
// Write right_foot only while no frame is being emitted or written.
module sensor_frame_aggregator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Input requests.
  input  wire logic                         s_tvalid_i,
  output logic                              s_tready_o,
  input  wire logic [sfa_pkg::IN_W-1:0]     s_tdata_i,   // [7:0] link_byte, [39:8] elapsed_us
  // Output words.
  output logic                              m_tvalid_o,
  input  wire logic                         m_tready_i,
  output logic [sfa_pkg::OUT_W-1:0]         m_tdata_o,   // [31:0] frame_word
  output logic                              m_tlast_o,   // last_word
  // Register port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sfa_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic           right_foot_q;
  logic           cfg_sel;
  logic           s_accept;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  sfa_pkg::cmd_t  front_cmd;
  sfa_pkg::cmd_t  q_cmd;

  // The single register decodes on the word address only.
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[sfa_pkg::PADDR_W-1:2] == sfa_pkg::REG_RIGHT_FOOT);
  assign prdata  = cfg_sel ? {31'b0, right_foot_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_foot_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      right_foot_q <= pwdata[0];
    end
  end

  // Every request is accepted while the queue has room, even one that
  // produces no command; this keeps the ready path free of parser state.
  assign s_tready_o = !q_full;
  assign s_accept   = s_tvalid_i && s_tready_o;

  sfa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (s_accept),
    .link_byte_i (s_tdata_i[7:0]),
    .elapsed_us_i(s_tdata_i[39:8]),
    .right_foot_i(right_foot_q),
    .push_o      (q_push),
    .cmd_o       (front_cmd)
  );

  sfa_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (front_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .cmd_o  (q_cmd),
    .empty_o(q_empty)
  );

  sfa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tlast_o (m_tlast_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sfa_checker.sv =====
// Port-level checks of the sensor frame aggregator, bound to its top level.
// Depends on sfa_pkg and sensor_frame_aggregator_assert.svh.
`default_nettype none

`include "sensor_frame_aggregator_assert.svh"

module sfa_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         m_tvalid_o,
  input wire logic                         m_tready_i,
  input wire logic [sfa_pkg::OUT_W-1:0]    m_tdata_o,
  input wire logic                         m_tlast_o,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [sfa_pkg::PADDR_W-1:0]  paddr,
  input wire logic [31:0]                  pwdata,
  input wire logic [31:0]                  prdata,
  input wire logic                         pready
);

  logic out_take;
  logic reg_write;

  assign out_take  = m_tvalid_o && m_tready_i;
  assign reg_write = psel && penable && pwrite && pready &&
                     (paddr[sfa_pkg::PADDR_W-1:2] == sfa_pkg::REG_RIGHT_FOOT);

  // A stalled word must stay put until it is taken.
  `SFA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o) && $stable(m_tlast_o), "output word changed while stalled")

  // Inside an emission the next word is ready right after one is taken.
  `SFA_ASSERT_NEXT(a_burst_gapless, clk_i, rst_ni, out_take && !m_tlast_o, m_tvalid_o, "gap inside an emission burst")

  // The register has one bit; the rest reads as zero.
  `SFA_ASSERT_NOW(a_prdata_upper, clk_i, rst_ni, 1'b1, prdata[31:1] == 31'b0, "unused register bits read nonzero")

  // A written value reads back on the following cycle.
  `SFA_ASSERT_NEXT(a_reg_readback, clk_i, rst_ni, reg_write, paddr[sfa_pkg::PADDR_W-1:2] != sfa_pkg::REG_RIGHT_FOOT || prdata[0] == $past(pwdata[0]), "right_foot readback mismatch")

endmodule

bind sensor_frame_aggregator sfa_checker u_sfa_checker (.*);

`default_nettype wire
